@@ rtl/page_frame_bitmap_allocator_macros.svh @@
// Assertion macros for the page frame allocator.
// Used by files that assert; expects clk and arst_n in scope.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pfba_pkg.sv @@
// Shared types and constants of the page frame allocator.
// No dependencies.
package pfba_pkg;

	localparam int WORD_W = 8;
	localparam int WSEL_W = $clog2(WORD_W);
	localparam int CNT_W  = $clog2(WORD_W + 1);

	localparam int POOL_SIZE_W = 13;
	localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 13'd4096;

	localparam logic [2:0] REQ_ALLOC     = 3'd0;
	localparam logic [2:0] REQ_ALLOC_RUN = 3'd1;
	localparam logic [2:0] REQ_FREE      = 3'd2;
	localparam logic [2:0] REQ_SHARE     = 3'd3;
	localparam logic [2:0] REQ_RELEASE   = 3'd4;
	localparam logic [2:0] REQ_MARK_USED = 3'd5;
	localparam logic [2:0] REQ_MARK_FREE = 3'd6;
	localparam logic [2:0] REQ_NONE      = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic [1:0] ST_BADCNT  = 2'd3;

	localparam logic CFG_POOL_BASE = 1'b0;
	localparam logic CFG_POOL_SIZE = 1'b1;

	localparam logic [7:0] SHARE_FIRST = 8'd2;
	localparam logic [7:0] SHARE_MAX   = 8'd255;

	typedef struct packed {
		logic              found;
		logic [WSEL_W-1:0] pos;
	} scan_res_t;

endpackage

@@ rtl/page_frame_bitmap_allocator.sv @@
// Page frame allocator. It takes one transaction at a time and holds busy high until it is done.
// A rejected or unknown request ends after setup; share and release read and write the share count,
// and a release that frees the frame then rewrites its bitmap word. Free and mark read and write each
// touched bitmap word of 8 frames; allocation scans words and then claims the run word by word.
// Reset clears state at once, then a clearing pass (busy high) fills the bitmap with used;
// a pool size write holds busy for a recount. No receiver stall.
`include "page_frame_bitmap_allocator_macros.svh"
module page_frame_bitmap_allocator
	import pfba_pkg::*;
#(
	parameter int FRAMES     = 4096,
	parameter int PAGE_SHIFT = 12,
	parameter int MAX_RUN    = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [2:0]                      req_type,
	input  logic [31:0]                     phys_addr,
	input  logic [8:0]                      page_count,
	output logic                            done,
	output logic [31:0]                     result_addr,
	output logic [1:0]                      status,
	output logic [$clog2(FRAMES+1)-1:0]     free_pages,
	output logic [7:0]                      ref_count,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [31:0]                     cfg_wdata
);

	localparam int FW    = $clog2(FRAMES);
	localparam int CW    = $clog2(FRAMES + 1);
	localparam int NW    = FRAMES / WORD_W;
	localparam int WI_W  = $clog2(NW);
	localparam int PW    = 32 - PAGE_SHIFT;
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SETUP, S_SCAN_RD, S_SCAN_EV,
		S_RMW_RD, S_RMW_WR, S_SH_RD, S_SH_WR, S_RC_RD, S_RC_WR
	} state_t;

	state_t                  state_q;
	logic [FW-1:0]           clr_q;
	logic [31:0]             pool_base_q;
	logic [POOL_SIZE_W-1:0]  pool_size_q;
	logic                    pend_q;
	logic [CW-1:0]           free_q;
	logic                    done_q;
	logic [31:0]             addr_q;
	logic [1:0]              status_q;
	logic [7:0]              refc_q;
	logic [2:0]              req_q;
	logic [PW-1:0]           page_q;
	logic [8:0]              cnt_q;
	logic [RUN_W-1:0]        need_q;
	logic [RUN_W-1:0]        run_q;
	logic [FW-1:0]           idx_q;
	logic [FW:0]             lo_q;
	logic [FW:0]             hi_q;
	logic                    setv_q;
	logic [WI_W-1:0]         wp_q;
	logic [CW-1:0]           acc_q;

	// effective pool size
	logic [CW-1:0] lim;
	assign lim = (32'(pool_size_q) > 32'(FRAMES)) ? CW'(FRAMES) : CW'(pool_size_q);

	assign busy        = (state_q != S_IDLE) || pend_q;
	assign done        = done_q;
	assign result_addr = addr_q;
	assign status      = status_q;
	assign free_pages  = free_q;
	assign ref_count   = refc_q;

	// request decode: pool membership and range clipping
	logic [31:0] page32, bb32, lim32, end32, rel32, rel_lo, rel_hi, ovr;
	logic        ge, in_pool, skipped, nonempty, bad_cnt;
	always_comb begin
		page32   = 32'(page_q);
		bb32     = 32'(pool_base_q[31:PAGE_SHIFT]);
		lim32    = 32'(lim);
		end32    = page32 + 32'(cnt_q);
		ge       = page32 >= bb32;
		rel32    = page32 - bb32;
		in_pool  = ge && (rel32 < lim32);
		rel_lo   = ge ? rel32 : '0;
		ovr      = end32 - bb32;
		rel_hi   = (end32 > bb32) ? ((ovr < lim32) ? ovr : lim32) : '0;
		skipped  = !ge || (end32 <= bb32) || (ovr > lim32);
		nonempty = rel_lo < rel_hi;
		bad_cnt  = (cnt_q == '0) || (32'(cnt_q) > 32'(MAX_RUN));
	end

	// bitmap RAM
	logic              bm_we;
	logic [WI_W-1:0]   bm_waddr;
	logic [WORD_W-1:0] bm_wdata, bm_rdata, new_word;
	logic [CNT_W-1:0]  chg, nfree;

	pfba_ram #(.DW(WORD_W), .DEPTH(NW), .AW(WI_W)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(wp_q), .rdata(bm_rdata)
	);

	pfba_word_ops #(.FW(FW), .WI_W(WI_W)) u_word_ops (
		.old_word(bm_rdata), .wp(wp_q), .lo(lo_q), .hi(hi_q), .set_val(setv_q),
		.new_word(new_word), .chg(chg), .nfree(nfree)
	);

	always_comb begin
		bm_we    = ((state_q == S_CLEAR) && (32'(clr_q) < 32'(NW)))
			|| (state_q == S_RMW_WR) || (state_q == S_RC_WR);
		bm_waddr = (state_q == S_CLEAR) ? clr_q[WI_W-1:0] : wp_q;
		bm_wdata = (state_q == S_CLEAR) ? '1 : new_word;
	end

	// share count RAM
	logic       sh_we;
	logic [FW-1:0] sh_waddr;
	logic [7:0] sh_wdata, sh_rdata, sh_new;
	logic       sh_drop;

	pfba_ram #(.DW(8), .DEPTH(FRAMES), .AW(FW)) u_share (
		.clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
		.raddr(idx_q), .rdata(sh_rdata)
	);

	always_comb begin
		sh_drop = (req_q == REQ_RELEASE) && (sh_rdata <= 8'd1);
		if (req_q == REQ_SHARE) begin
			if (sh_rdata == '0)
				sh_new = SHARE_FIRST;
			else if (sh_rdata < SHARE_MAX)
				sh_new = sh_rdata + 8'd1;
			else
				sh_new = sh_rdata;
		end else begin
			sh_new = (sh_rdata > 8'd1) ? sh_rdata - 8'd1 : '0;
		end
		sh_we    = (state_q == S_CLEAR) || (state_q == S_SH_WR);
		sh_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
		sh_wdata = (state_q == S_CLEAR) ? '0 : sh_new;
	end

	// first-fit scan step
	scan_res_t        sres;
	logic [RUN_W-1:0] run_nxt;
	logic [FW:0]      end_c, lo_c;
	logic [31:0]      base_al;
	logic [FW:0]      hm1;

	pfba_scan #(.RUN_W(RUN_W)) u_scan (
		.used(bm_rdata), .run_in(run_q), .need(need_q), .res(sres), .run_out(run_nxt)
	);

	always_comb begin
		end_c   = (FW+1)'({wp_q, sres.pos}) + 1'b1;
		lo_c    = end_c - (FW+1)'(need_q);
		base_al = {pool_base_q[31:PAGE_SHIFT], PAGE_SHIFT'(0)};
		hm1     = hi_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			pool_base_q  <= '0;
			pool_size_q  <= POOL_SIZE_RST;
			pend_q       <= 1'b0;
			free_q       <= '0;
			done_q       <= 1'b0;
			addr_q       <= '0;
			status_q     <= ST_OK;
			refc_q       <= '0;
			req_q        <= '0;
			page_q       <= '0;
			cnt_q        <= '0;
			need_q       <= '0;
			run_q        <= '0;
			idx_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			setv_q       <= 1'b0;
			wp_q         <= '0;
			acc_q        <= '0;
		end else begin
			done_q <= 1'b0;

			// config writes land any time; a new pool size requests a recount
			if (cfg_we) begin
				if (cfg_index == CFG_POOL_BASE)
					pool_base_q <= cfg_wdata;
				else
					pool_size_q <= cfg_wdata[POOL_SIZE_W-1:0];
			end
			if (cfg_we && (cfg_index == CFG_POOL_SIZE))
				pend_q <= 1'b1;
			else if ((state_q == S_IDLE) && pend_q)
				pend_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(FRAMES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pend_q) begin
						// force frames beyond the limit to used and recount
						wp_q    <= '0;
						acc_q   <= '0;
						lo_q    <= (FW+1)'(lim);
						hi_q    <= (FW+1)'(FRAMES);
						setv_q  <= 1'b1;
						state_q <= S_RC_RD;
					end else if (start) begin
						req_q    <= req_type;
						page_q   <= phys_addr[31:PAGE_SHIFT];
						cnt_q    <= page_count;
						addr_q   <= '0;
						status_q <= ST_OK;
						refc_q   <= '0;
						state_q  <= S_SETUP;
					end
				end
				S_SETUP: begin
					priority case (req_q)
						REQ_ALLOC, REQ_ALLOC_RUN: begin
							if ((req_q == REQ_ALLOC_RUN) && bad_cnt) begin
								status_q <= ST_BADCNT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								need_q  <= (req_q == REQ_ALLOC) ? RUN_W'(1) : RUN_W'(cnt_q);
								run_q   <= '0;
								wp_q    <= '0;
								state_q <= S_SCAN_RD;
							end
						end
						REQ_FREE: begin
							if (!in_pool) begin
								status_q <= ST_OUTSIDE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								lo_q    <= (FW+1)'(rel32);
								hi_q    <= (FW+1)'(rel32) + 1'b1;
								setv_q  <= 1'b0;
								wp_q    <= rel32[WSEL_W +: WI_W];
								state_q <= S_RMW_RD;
							end
						end
						REQ_SHARE, REQ_RELEASE: begin
							if (!in_pool) begin
								status_q <= ST_OUTSIDE;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								idx_q   <= FW'(rel32);
								state_q <= S_SH_RD;
							end
						end
						REQ_MARK_USED, REQ_MARK_FREE: begin
							if (bad_cnt) begin
								status_q <= ST_BADCNT;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								status_q <= skipped ? ST_OUTSIDE : ST_OK;
								if (nonempty) begin
									lo_q    <= (FW+1)'(rel_lo);
									hi_q    <= (FW+1)'(rel_hi);
									setv_q  <= (req_q == REQ_MARK_USED);
									wp_q    <= rel_lo[WSEL_W +: WI_W];
									state_q <= S_RMW_RD;
								end else begin
									done_q  <= 1'b1;
									state_q <= S_IDLE;
								end
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (sres.found) begin
						// claim the run; all its frames are free
						lo_q    <= lo_c;
						hi_q    <= end_c;
						setv_q  <= 1'b1;
						wp_q    <= lo_c[WSEL_W +: WI_W];
						addr_q  <= base_al + (32'(lo_c) << PAGE_SHIFT);
						state_q <= S_RMW_RD;
					end else if (wp_q == WI_W'(NW - 1)) begin
						status_q <= ST_NOSPACE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						run_q   <= run_nxt;
						wp_q    <= wp_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: begin
					free_q <= setv_q ? free_q - CW'(chg) : free_q + CW'(chg);
					if (wp_q == hm1[WSEL_W +: WI_W]) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						wp_q    <= wp_q + 1'b1;
						state_q <= S_RMW_RD;
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					refc_q <= sh_new;
					if (sh_drop) begin
						// last owner gone: free the frame
						lo_q    <= (FW+1)'(idx_q);
						hi_q    <= (FW+1)'(idx_q) + 1'b1;
						setv_q  <= 1'b0;
						wp_q    <= idx_q[WSEL_W +: WI_W];
						state_q <= S_RMW_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RC_RD: state_q <= S_RC_WR;
				S_RC_WR: begin
					acc_q <= acc_q + CW'(nfree);
					if (wp_q == WI_W'(NW - 1)) begin
						free_q  <= acc_q + CW'(nfree);
						state_q <= S_IDLE;
					end else begin
						wp_q    <= wp_q + 1'b1;
						state_q <= S_RC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PFBA_ASSERT_NXT(a_done_pulse, done, !done, "done held for more than one cycle")
	`PFBA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy low after an accepted transaction")
	`PFBA_ASSERT_IMP(a_free_bound, 1'b1, free_q <= CW'(FRAMES), "free count above pool size")
	`PFBA_ASSERT_IMP(a_fail_addr, done && (status != ST_OK), result_addr == '0, "address on failure")

endmodule

@@ rtl/pfba_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pfba_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/pfba_scan.sv @@
// First-fit step over one bitmap word: extends the free run bit by bit.
// Depends on pfba_pkg.
module pfba_scan
	import pfba_pkg::*;
#(
	parameter int RUN_W = 9
) (
	input  logic [WORD_W-1:0] used,
	input  logic [RUN_W-1:0]  run_in,
	input  logic [RUN_W-1:0]  need,
	output scan_res_t         res,
	output logic [RUN_W-1:0]  run_out
);

	always_comb begin
		logic [RUN_W-1:0] run;
		run = run_in;
		res = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (!res.found) begin
				run = used[j] ? '0 : run + 1'b1;
				if (run == need) begin
					res.found = 1'b1;
					res.pos   = WSEL_W'(j);
				end
			end
		end
		run_out = run;
	end

endmodule

@@ rtl/pfba_word_ops.sv @@
// Range mask, set/clear and bit counts for one bitmap word.
// Depends on pfba_pkg.
module pfba_word_ops
	import pfba_pkg::*;
#(
	parameter int FW   = 12,
	parameter int WI_W = 9
) (
	input  logic [WORD_W-1:0] old_word,
	input  logic [WI_W-1:0]   wp,
	input  logic [FW:0]       lo,
	input  logic [FW:0]       hi,
	input  logic              set_val,
	output logic [WORD_W-1:0] new_word,
	output logic [CNT_W-1:0]  chg,
	output logic [CNT_W-1:0]  nfree
);

	always_comb begin
		logic [WORD_W-1:0] m;
		logic [FW:0]       f;
		m = '0;
		for (int b = 0; b < WORD_W; b++) begin
			f = (FW+1)'({wp, WSEL_W'(b)});
			m[b] = (f >= lo) && (f < hi);
		end
		new_word = set_val ? (old_word | m) : (old_word & ~m);
		chg   = '0;
		nfree = '0;
		for (int b = 0; b < WORD_W; b++) begin
			chg   = chg + CNT_W'(old_word[b] ^ new_word[b]);
			nfree = nfree + CNT_W'(!new_word[b]);
		end
	end

endmodule

@@ tb/sv/page_frame_bitmap_allocator_checker.sv @@
// Checker for the page frame allocator: predicts every reply and compares it.
// Depends on pfba_pkg; watches the request, reply and register write ports.
`timescale 1ns / 1ps
module page_frame_bitmap_allocator_checker
	import pfba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] phys_addr,
	input  logic [8:0]  page_count,
	input  logic        done,
	input  logic [31:0] result_addr,
	input  logic [1:0]  status,
	input  logic [12:0] free_pages,
	input  logic [7:0]  ref_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	output int          pending,
	output int          errors
);

	localparam int NFRAMES = 4096;
	localparam int SHIFT   = 12;
	localparam int RUN_MAX = 256;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  st;
		logic [12:0] free;
		logic [7:0]  refc;
	} reply_t;

	logic [31:0] base_reg;
	logic [12:0] pages_reg;
	bit          frame_used [NFRAMES];
	logic [7:0]  sharers [NFRAMES];
	int          free_count;
	reply_t      replies_due [$];

	function automatic int pool_limit();
		return (pages_reg > NFRAMES) ? NFRAMES : int'(pages_reg);
	endfunction

	function automatic bit locate(input int page, output int idx);
		int bb;
		bb = int'(base_reg >> SHIFT);
		idx = page - bb;
		return (page >= bb) && (idx < pool_limit());
	endfunction

	function automatic void mark(input int idx, input bit used);
		if (used && !frame_used[idx]) begin
			frame_used[idx] = 1'b1;
			free_count--;
		end else if (!used && frame_used[idx]) begin
			frame_used[idx] = 1'b0;
			free_count++;
		end
	endfunction

	function automatic reply_t predict_frame_request(input logic [2:0] rt,
		input logic [31:0] pa, input logic [8:0] pc);
		reply_t r;
		int page, cnt, lim, idx, run, need, i;
		bit found, bad;
		r = '0;
		page = int'(pa >> SHIFT);
		cnt = int'(pc);
		lim = pool_limit();
		bad = (cnt == 0) || (cnt > RUN_MAX);
		case (rt)
			REQ_ALLOC, REQ_ALLOC_RUN: begin
				need = (rt == REQ_ALLOC) ? 1 : cnt;
				if (rt == REQ_ALLOC_RUN && bad) begin
					r.st = ST_BADCNT;
				end else begin
					run = 0;
					found = 0;
					for (i = 0; i < lim; i++) begin
						run = frame_used[i] ? 0 : run + 1;
						if (run == need) begin
							found = 1;
							break;
						end
					end
					if (!found) begin
						r.st = ST_NOSPACE;
					end else begin
						idx = i + 1 - need;
						for (int k = 0; k < need; k++)
							mark(idx + k, 1'b1);
						r.addr = ((base_reg >> SHIFT) << SHIFT) + (32'(idx) << SHIFT);
					end
				end
			end
			REQ_FREE: begin
				if (!locate(page, idx))
					r.st = ST_OUTSIDE;
				else
					mark(idx, 1'b0);
			end
			REQ_SHARE: begin
				if (!locate(page, idx)) begin
					r.st = ST_OUTSIDE;
				end else begin
					if (sharers[idx] == 0)
						sharers[idx] = SHARE_FIRST;
					else if (sharers[idx] != SHARE_MAX)
						sharers[idx]++;
					r.refc = sharers[idx];
				end
			end
			REQ_RELEASE: begin
				if (!locate(page, idx)) begin
					r.st = ST_OUTSIDE;
				end else begin
					if (sharers[idx] > 1) begin
						sharers[idx]--;
					end else begin
						sharers[idx] = 0;
						mark(idx, 1'b0);
					end
					r.refc = sharers[idx];
				end
			end
			REQ_MARK_USED, REQ_MARK_FREE: begin
				if (bad) begin
					r.st = ST_BADCNT;
				end else begin
					for (i = 0; i < cnt; i++) begin
						if (locate(page + i, idx))
							mark(idx, rt == REQ_MARK_USED);
						else
							r.st = ST_OUTSIDE;
					end
				end
			end
			default: ;
		endcase
		r.free = 13'(free_count);
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	// State after reset: every frame used, no sharers, nothing free.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			base_reg = '0;
			pages_reg = POOL_SIZE_RST;
			for (int i = 0; i < NFRAMES; i++) begin
				frame_used[i] = 1'b1;
				sharers[i] = '0;
			end
			free_count = 0;
			replies_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_POOL_BASE) begin
					base_reg = cfg_wdata;
				end else begin
					pages_reg = cfg_wdata[12:0];
					free_count = 0;
					for (int i = 0; i < NFRAMES; i++) begin
						if (i >= pool_limit())
							frame_used[i] = 1'b1;
						if (!frame_used[i])
							free_count++;
					end
				end
			end
			if (done) begin
				if (replies_due.size() == 0) begin
					report("unexpected reply", result_addr, 0);
				end else begin
					want = replies_due.pop_front();
					if (result_addr !== want.addr)
						report("result_addr", result_addr, want.addr);
					if (status !== want.st)
						report("status", status, want.st);
					if (free_pages !== want.free)
						report("free_pages", free_pages, want.free);
					if (ref_count !== want.refc)
						report("ref_count", ref_count, want.refc);
				end
			end
			if (start && !busy)
				replies_due.push_back(predict_frame_request(req_type, phys_addr, page_count));
		end
		pending = replies_due.size();
	end

endmodule

@@ tb/sv/page_frame_bitmap_allocator_tb.sv @@
// Testbench top for the page frame allocator: clock, reset, stimulus and verdict.
// Depends on pfba_pkg, the allocator RTL and page_frame_bitmap_allocator_checker.
`timescale 1ns / 1ps
module page_frame_bitmap_allocator_tb;
	import pfba_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [31:0] phys_addr;
	logic [8:0]  page_count;
	logic        done;
	logic [31:0] result_addr;
	logic [1:0]  status;
	logic [12:0] free_pages;
	logic [7:0]  ref_count;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	int          pending;
	int          errors;
	int          cycles;

	// Shadow of the pool registers, used only to aim addresses at the pool.
	logic [31:0] cur_base;
	int          cur_lim;
	bit          steady;

	page_frame_bitmap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .phys_addr(phys_addr), .page_count(page_count),
		.done(done), .result_addr(result_addr), .status(status),
		.free_pages(free_pages), .ref_count(ref_count),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	page_frame_bitmap_allocator_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .phys_addr(phys_addr), .page_count(page_count),
		.done(done), .result_addr(result_addr), .status(status),
		.free_pages(free_pages), .ref_count(ref_count),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.pending(pending), .errors(errors)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: the slowest legal run stays far below this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Hold until busy is low; busy is read mid-cycle so no edge race is possible.
	// Returns on the rising edge where the block takes the transaction.
	task automatic wait_ready();
		bit ready;
		do begin
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
		end while (!ready);
	endtask

	// Present one transaction; start stays high so back-to-back requests need
	// no lowering in between. Random gaps, skipped while steady is set, lower it.
	task automatic send(input logic [2:0] rt, input logic [31:0] pa, input logic [8:0] pc);
		if (!steady && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= rt;
		phys_addr  <= pa;
		page_count <= pc;
		wait_ready();
	endtask

	// Drop start and hold until every reply is back, plus a margin for the
	// block to settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] data);
		drain();
		wait_ready();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		// a pool size write starts a recount with busy high
		wait_ready();
	endtask

	task automatic set_pool(input logic [31:0] base, input logic [12:0] pages);
		write_reg(CFG_POOL_BASE, base);
		write_reg(CFG_POOL_SIZE, 32'(pages));
		cur_base = base;
		cur_lim = (pages > 4096) ? 4096 : int'(pages);
	endtask

	function automatic logic [31:0] frame_address(input int idx);
		return (((cur_base >> 12) + 32'(idx)) << 12) | 32'($urandom_range(0, 4095));
	endfunction

	// Mostly in-pool addresses, a few around the pool edges and some noise.
	function automatic logic [31:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return frame_address($urandom_range(0, 3));
		if (r < 80 && cur_lim > 0)
			return frame_address($urandom_range(0, cur_lim - 1));
		if (r < 90)
			return frame_address($urandom_range(0, 8) + cur_lim - 4);
		if (r < 94)
			return cur_base - 32'($urandom_range(1, 8) << 12);
		return $urandom;
	endfunction

	function automatic logic [8:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 9'($urandom_range(1, 8));
		if (r < 92)
			return 9'($urandom_range(1, 256));
		return 9'($urandom);
	endfunction

	task automatic random_requests(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 14)
				send(REQ_ALLOC, $urandom, 9'($urandom));
			else if (r < 28)
				send(REQ_ALLOC_RUN, $urandom, pick_count());
			else if (r < 42)
				send(REQ_FREE, pick_address(), 9'($urandom));
			else if (r < 58)
				send(REQ_SHARE, pick_address(), 9'($urandom));
			else if (r < 74)
				send(REQ_RELEASE, pick_address(), 9'($urandom));
			else if (r < 83)
				send(REQ_MARK_USED, pick_address(), pick_count());
			else if (r < 98)
				send(REQ_MARK_FREE, pick_address(), pick_count());
			else
				send(REQ_NONE, $urandom, 9'($urandom));
		end
	endtask

	initial begin
		cycles     = 0;
		steady     = 0;
		cur_base   = '0;
		cur_lim    = 4096;
		arst_n     = 1'b0;
		start      = 1'b0;
		req_type   = REQ_ALLOC;
		phys_addr  = '0;
		page_count = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_POOL_BASE;
		cfg_wdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass keeps busy high for a while
		wait_ready();

		// Directed: reset pool, nothing free yet.
		send(REQ_ALLOC, '0, '0);
		send(REQ_ALLOC_RUN, '0, 9'd1);
		send(REQ_MARK_FREE, 32'h0000_0000, 9'd256);
		send(REQ_ALLOC, '0, '0);
		send(REQ_ALLOC_RUN, '0, 9'd256);
		send(REQ_ALLOC_RUN, '0, 9'd255);
		send(REQ_ALLOC_RUN, '0, 9'd0);
		send(REQ_ALLOC_RUN, '0, 9'd257);
		send(REQ_MARK_USED, 32'h0000_1000, 9'd511);
		send(REQ_FREE, 32'h0000_0fff, '0);
		send(REQ_FREE, 32'h0000_0000, '0);
		send(REQ_SHARE, 32'h0000_5000, '0);
		send(REQ_SHARE, 32'h0000_5abc, '0);
		send(REQ_RELEASE, 32'h0000_5000, '0);
		send(REQ_RELEASE, 32'h0000_5000, '0);
		send(REQ_RELEASE, 32'h0000_5000, '0);
		send(REQ_SHARE, 32'hffff_f000, '0);
		send(REQ_FREE, 32'hffff_ffff, '0);
		send(REQ_RELEASE, 32'h0100_0000, '0);
		send(REQ_NONE, 32'hffff_ffff, 9'h1ff);
		send(REQ_MARK_FREE, 32'h00ff_a000, 9'd10);
		send(REQ_MARK_USED, 32'h00fa_0000, 9'd256);
		send(REQ_ALLOC_RUN, '0, 9'd2);

		// Saturate one share count, then step it down by four releases.
		steady = 1;
		repeat (258) send(REQ_SHARE, 32'h0000_7000, '0);
		repeat (4) send(REQ_RELEASE, 32'h0000_7000, '0);
		steady = 0;
		random_requests(120);

		// Pressure: pause until every reply is back, then resume.
		drain();
		random_requests(60);

		set_pool(32'h8000_0000, 13'd64);
		send(REQ_MARK_FREE, 32'h8000_0000, 9'd64);
		steady = 1;
		random_requests(150);
		steady = 0;

		set_pool(32'h1234_5abc, 13'd0);
		random_requests(40);

		set_pool(32'hffff_f000, 13'h1fff);
		send(REQ_MARK_FREE, 32'hffff_f000, 9'd256);
		random_requests(60);

		set_pool(32'h0040_0000, 13'd512);
		send(REQ_MARK_FREE, 32'h0040_0000, 9'd200);
		random_requests(180);

		drain();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ page_frame_bitmap_allocator.f @@
+incdir+rtl
rtl/pfba_pkg.sv
rtl/pfba_ram.sv
rtl/pfba_scan.sv
rtl/pfba_word_ops.sv
rtl/page_frame_bitmap_allocator.sv
tb/sv/page_frame_bitmap_allocator_checker.sv
tb/sv/page_frame_bitmap_allocator_tb.sv
